>>> rtl/vpfa_pkg.sv
// ----------------------------------------------------------------------------
// vpfa_pkg: shared types and constants for volume and pan automation
// Item layouts, command codes, level limits and the counter load helper.
// ----------------------------------------------------------------------------
package vpfa_pkg;

   // Command codes carried in the command field of an input item.
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_SET_VOL   = 3'd1,
      CMD_REL_VOL   = 3'd2,
      CMD_SET_PAN   = 3'd3,
      CMD_PAN_FADE  = 3'd4,
      CMD_VOL_FADE  = 3'd5
   } vpfa_cmd_type;

   // Pan limits: full right and center.
   localparam logic [7:0] PAN_MAX    = 8'd30;
   localparam logic [7:0] PAN_CENTER = 8'd15;

   // One input item.
   typedef struct packed {
      logic [2:0]        command;
      logic [7:0]        level_value;
      logic signed [7:0] fade_step;
      logic [7:0]        delay;
      logic [7:0]        interval;
      logic [7:0]        count;
      logic [7:0]        endpoint;
   } vpfa_req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] volume_level;
      logic [7:0] pan_position;
      logic       volume_changed;
      logic       pan_changed;
   } vpfa_rsp_type;

   // Status returned by one level unit for the item being processed.
   typedef struct packed {
      logic [7:0] level;
      logic       changed;
   } vpfa_lvl_type;

   // An 8-bit counter load where zero stands for 256.
   function automatic logic [8:0] load_count(input logic [7:0] v);
      return {~|v, v};
   endfunction

endpackage

>>> rtl/vpfa_vol.sv
// ----------------------------------------------------------------------------
// vpfa_vol: volume level and volume fade unit
// Holds the track volume and its fade counters and applies one item a cycle when go is high.
// ----------------------------------------------------------------------------
module vpfa_vol (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  vpfa_pkg::vpfa_req_type item,
   output vpfa_pkg::vpfa_lvl_type status
);

   logic [7:0] level_ff, level_in;
   logic       on_ff, on_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] period_ff, period_in;
   logic [7:0] delta_ff, delta_in;
   logic [8:0] left_ff, left_in;
   logic       changed;
   logic [8:0] count_dec;
   logic [8:0] left_dec;

   assign count_dec = count_ff - 9'd1;
   assign left_dec  = left_ff - 9'd1;

   // Next state of the volume and its fade for the current item.
   always_comb begin
      level_in  = level_ff;
      on_in     = on_ff;
      count_in  = count_ff;
      period_in = period_ff;
      delta_in  = delta_ff;
      left_in   = left_ff;
      changed   = 1'b0;
      unique case (item.command)
         vpfa_pkg::CMD_TICK: begin
            if (on_ff) begin
               count_in = count_dec;
               if (count_dec == 9'd0) begin
                  level_in = level_ff + delta_ff;
                  changed  = 1'b1;
                  left_in  = left_dec;
                  if (left_dec == 9'd0) begin
                     on_in = 1'b0;
                  end else begin
                     count_in = period_ff;
                  end
               end
            end
         end
         vpfa_pkg::CMD_SET_VOL: begin
            on_in    = 1'b0;
            level_in = item.level_value;
            changed  = 1'b1;
         end
         vpfa_pkg::CMD_REL_VOL: begin
            on_in    = 1'b0;
            level_in = level_ff + item.level_value;
            changed  = 1'b1;
         end
         vpfa_pkg::CMD_VOL_FADE: begin
            on_in     = (item.fade_step != 8'sd0);
            count_in  = vpfa_pkg::load_count(item.delay + item.interval);
            period_in = vpfa_pkg::load_count(item.interval);
            delta_in  = $unsigned(item.fade_step);
            left_in   = vpfa_pkg::load_count(item.count);
         end
         default: begin
         end
      endcase
   end

   assign status.level   = level_in;
   assign status.changed = changed;

   // State registers, updated when an item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= 8'd0;
         on_ff     <= 1'b0;
         count_ff  <= 9'd0;
         period_ff <= 9'd1;
         delta_ff  <= 8'd0;
         left_ff   <= 9'd0;
      end else if (go) begin
         level_ff  <= level_in;
         on_ff     <= on_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         delta_ff  <= delta_in;
         left_ff   <= left_in;
      end
   end

endmodule

>>> rtl/vpfa_pan.sv
// ----------------------------------------------------------------------------
// vpfa_pan: pan position and pan fade unit
// Holds the pan position, fade goal and direction and applies one item a cycle when go is high.
// ----------------------------------------------------------------------------
module vpfa_pan (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  vpfa_pkg::vpfa_req_type item,
   output vpfa_pkg::vpfa_lvl_type status
);

   logic [7:0] pan_ff, pan_in;
   logic       on_ff, on_in;
   logic       bounce_ff, bounce_in;
   logic [8:0] count_ff, count_in;
   logic [8:0] period_ff, period_in;
   logic [4:0] goal_ff, goal_in;
   logic       down_ff, down_in;
   logic       changed;
   logic [8:0] count_dec;
   logic [7:0] pan_step;
   logic [4:0] new_goal;
   logic [7:0] raw_period;

   assign count_dec  = count_ff - 9'd1;
   assign pan_step   = pan_ff + (down_ff ? 8'hFF : 8'd1);
   assign new_goal   = (item.endpoint[7:1] > 7'(vpfa_pkg::PAN_MAX)) ?
                       5'(vpfa_pkg::PAN_MAX) : item.endpoint[5:1];
   assign raw_period = item.interval + 8'd1;

   // Next state of the pan and its fade for the current item.
   always_comb begin
      pan_in    = pan_ff;
      on_in     = on_ff;
      bounce_in = bounce_ff;
      count_in  = count_ff;
      period_in = period_ff;
      goal_in   = goal_ff;
      down_in   = down_ff;
      changed   = 1'b0;
      unique case (item.command)
         vpfa_pkg::CMD_TICK: begin
            if (on_ff) begin
               count_in = count_dec;
               if (count_dec == 9'd0) begin
                  pan_in   = pan_step;
                  changed  = 1'b1;
                  count_in = period_ff;
                  // Goal reached: stop, or mirror the goal and turn around.
                  if (pan_step == {3'd0, goal_ff}) begin
                     if (!bounce_ff) begin
                        on_in = 1'b0;
                     end else begin
                        goal_in = 5'(vpfa_pkg::PAN_MAX) - goal_ff;
                        down_in = !down_ff;
                     end
                  end
               end
            end
         end
         vpfa_pkg::CMD_SET_PAN: begin
            on_in   = 1'b0;
            pan_in  = (item.level_value > vpfa_pkg::PAN_MAX) ?
                      vpfa_pkg::PAN_MAX : item.level_value;
            changed = 1'b1;
         end
         vpfa_pkg::CMD_PAN_FADE: begin
            on_in     = (pan_ff != {3'd0, new_goal});
            bounce_in = !item.endpoint[0];
            count_in  = vpfa_pkg::load_count(raw_period + item.delay);
            period_in = vpfa_pkg::load_count(raw_period);
            goal_in   = new_goal;
            down_in   = !({3'd0, new_goal} > pan_ff);
         end
         default: begin
         end
      endcase
   end

   assign status.level   = pan_in;
   assign status.changed = changed;

   // State registers, updated when an item moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_ff    <= vpfa_pkg::PAN_CENTER;
         on_ff     <= 1'b0;
         bounce_ff <= 1'b0;
         count_ff  <= 9'd0;
         period_ff <= 9'd1;
         goal_ff   <= 5'(vpfa_pkg::PAN_CENTER);
         down_ff   <= 1'b0;
      end else if (go) begin
         pan_ff    <= pan_in;
         on_ff     <= on_in;
         bounce_ff <= bounce_in;
         count_ff  <= count_in;
         period_ff <= period_in;
         goal_ff   <= goal_in;
         down_ff   <= down_in;
      end
   end

endmodule

>>> rtl/volume_pan_fade_automation.sv
// ----------------------------------------------------------------------------
// volume_pan_fade_automation: per-track volume and pan automation
// Input register, volume and pan units, and a result register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low and returns
// exactly one result item for each, in order. An accepted item is registered
// in the input register; the volume and pan units then update their state and
// the result register in a single pass once that register is free or being
// emptied, and the result stays on the output while rsp_stall is high. The
// result register and the input register together let a new item in while a
// finished result still waits; req_stall rises only when both registers are
// full and rsp_stall holds the result.
// Unused command codes leave all state unchanged and return the current levels.
module volume_pan_fade_automation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vpfa_pkg::vpfa_req_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output vpfa_pkg::vpfa_rsp_type rsp_item
);

   logic                   in_valid_ff, in_valid_in;
   vpfa_pkg::vpfa_req_type in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   vpfa_pkg::vpfa_rsp_type out_item_ff;
   vpfa_pkg::vpfa_lvl_type vol_status;
   vpfa_pkg::vpfa_lvl_type pan_status;
   logic                   go;
   logic                   req_take;

   // An item advances when the result register is free or being emptied.
   assign go        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !go);
   assign out_valid_in = go || (out_valid_ff && rsp_stall);

   vpfa_vol u_vol (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .item   (in_item_ff),
      .status (vol_status)
   );

   vpfa_pan u_pan (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .item   (in_item_ff),
      .status (pan_status)
   );

   // Handshake control for the two register stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (go) begin
         out_item_ff.volume_level   <= vol_status.level;
         out_item_ff.pan_position   <= pan_status.level;
         out_item_ff.volume_changed <= vol_status.changed;
         out_item_ff.pan_changed    <= pan_status.changed;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // An item that advances always yields a result in the next cycle.
   a_go_gives_result: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid)
      else $error("advanced item produced no result");

   // The input side is never stalled while the input register is empty.
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with empty input register");

   // Only ticks and set-pan commands can move the pan.
   a_pan_flag_source: assert property (@(posedge clock) disable iff (reset)
      go && (in_item_ff.command != vpfa_pkg::CMD_TICK)
         && (in_item_ff.command != vpfa_pkg::CMD_SET_PAN)
      |=> !rsp_item.pan_changed)
      else $error("pan flagged on a command that cannot change it");

   // A set-pan result is clamped to full right.
   a_set_pan_clamped: assert property (@(posedge clock) disable iff (reset)
      go && (in_item_ff.command == vpfa_pkg::CMD_SET_PAN)
      |=> rsp_item.pan_changed && (rsp_item.pan_position <= vpfa_pkg::PAN_MAX))
      else $error("set pan result out of range");

   // Starting a volume fade changes neither level.
   a_fade_start_quiet: assert property (@(posedge clock) disable iff (reset)
      go && (in_item_ff.command == vpfa_pkg::CMD_VOL_FADE)
      |=> !rsp_item.volume_changed && !rsp_item.pan_changed)
      else $error("volume fade start raised a change flag");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for volume and pan automation
// Drives ticks and commands through the valid/stall request channel and checks
// every result item against a level predictor kept in step with the block.
// A short table of directed items comes first, then constrained random items
// with random bursts, gaps, output stalls and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;

   // Command codes the block does not define.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS = 1800;
   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 60;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_EVERY_THIRD
   } stall_kind_type;

   typedef struct {
      vpfa_pkg::vpfa_req_type item;
      bit                     typed;
      vpfa_pkg::vpfa_rsp_type want;
   } level_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   vpfa_pkg::vpfa_req_type req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   vpfa_pkg::vpfa_rsp_type rsp_item;

   // Predicted block state, starting from its reset values.
   logic [7:0] vol_lvl     = 8'd0;
   logic [7:0] pan_lvl     = 8'd15;
   logic       vf_active   = 1'b0;
   logic [8:0] vf_cnt      = 9'd0;
   logic [8:0] vf_period   = 9'd1;
   logic [7:0] vf_step     = 8'd0;
   logic [8:0] vf_left     = 9'd0;
   logic       pf_active   = 1'b0;
   logic       pf_bounce   = 1'b0;
   logic [8:0] pf_cnt      = 9'd0;
   logic [8:0] pf_period   = 9'd1;
   logic [7:0] pf_goal     = 8'd15;
   logic       pf_down     = 1'b0;

   level_row_type          directed[$];
   vpfa_pkg::vpfa_rsp_type levels_due[$];
   int                     mismatch_count = 0;
   int                     results_seen   = 0;
   int                     cycle_total    = 0;
   int                     burst_left     = 0;
   int                     hold_left      = 0;
   int                     stall_clock    = 0;
   stall_kind_type         stall_mode     = STALL_NONE;
   logic                   hold_active    = 1'b0;

   volume_pan_fade_automation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   // An 8-bit counter load value where zero stands for 256.
   function automatic logic [8:0] count_of(input logic [7:0] v);
      count_of = (v == 8'd0) ? 9'd256 : {1'b0, v};
   endfunction

   // Advances the predicted levels by one item and returns the result it gives.
   task automatic predict_levels(input vpfa_pkg::vpfa_req_type it,
                                 output vpfa_pkg::vpfa_rsp_type res);
      logic [7:0] target;
      logic [7:0] first;
      logic       vchg;
      logic       pchg;
      vchg = 1'b0;
      pchg = 1'b0;
      case (it.command)
         vpfa_pkg::CMD_TICK: begin
            // Volume fade: count down, then apply one step.
            if (vf_active) begin
               vf_cnt = vf_cnt - 9'd1;
               if (vf_cnt == 9'd0) begin
                  vol_lvl = vol_lvl + vf_step;
                  vchg    = 1'b1;
                  vf_left = vf_left - 9'd1;
                  if (vf_left == 9'd0) begin
                     vf_active = 1'b0;
                  end else begin
                     vf_cnt = vf_period;
                  end
               end
            end
            // Pan fade: count down, then move one position toward the goal.
            if (pf_active) begin
               pf_cnt = pf_cnt - 9'd1;
               if (pf_cnt == 9'd0) begin
                  pan_lvl = pf_down ? pan_lvl - 8'd1 : pan_lvl + 8'd1;
                  pchg    = 1'b1;
                  if (pan_lvl == pf_goal) begin
                     if (!pf_bounce) begin
                        pf_active = 1'b0;
                     end else begin
                        pf_goal = vpfa_pkg::PAN_MAX - pf_goal;
                        pf_down = !pf_down;
                     end
                  end
                  pf_cnt = pf_period;
               end
            end
         end
         vpfa_pkg::CMD_SET_VOL: begin
            vf_active = 1'b0;
            vol_lvl   = it.level_value;
            vchg      = 1'b1;
         end
         vpfa_pkg::CMD_REL_VOL: begin
            vf_active = 1'b0;
            vol_lvl   = vol_lvl + it.level_value;
            vchg      = 1'b1;
         end
         vpfa_pkg::CMD_SET_PAN: begin
            pf_active = 1'b0;
            pan_lvl   = (it.level_value > vpfa_pkg::PAN_MAX) ?
                        vpfa_pkg::PAN_MAX : it.level_value;
            pchg      = 1'b1;
         end
         vpfa_pkg::CMD_PAN_FADE: begin
            target = {1'b0, it.endpoint[7:1]};
            if (target > vpfa_pkg::PAN_MAX) begin
               target = vpfa_pkg::PAN_MAX;
            end
            first     = it.interval + 8'd1;
            pf_active = (pan_lvl != target);
            pf_bounce = !it.endpoint[0];
            pf_cnt    = count_of(first + it.delay);
            pf_period = count_of(first);
            pf_goal   = target;
            pf_down   = !(target > pan_lvl);
         end
         vpfa_pkg::CMD_VOL_FADE: begin
            vf_active = (it.fade_step != 8'sd0);
            vf_cnt    = count_of(it.delay + it.interval);
            vf_period = count_of(it.interval);
            vf_step   = it.fade_step;
            vf_left   = count_of(it.count);
         end
         default: begin
         end
      endcase
      res.volume_level   = vol_lvl;
      res.pan_position   = pan_lvl;
      res.volume_changed = vchg;
      res.pan_changed    = pchg;
   endtask

   task automatic add_row(input logic [2:0] cmd,
                          input logic [7:0] value, step, dly, ivl, cnt, endp,
                          input bit typed, input logic [7:0] vol, pan,
                          input bit vchg, input bit pchg);
      level_row_type r;
      r.item.command      = cmd;
      r.item.level_value  = value;
      r.item.fade_step    = step;
      r.item.delay        = dly;
      r.item.interval     = ivl;
      r.item.count        = cnt;
      r.item.endpoint     = endp;
      r.typed             = typed;
      r.want.volume_level   = vol;
      r.want.pan_position   = pan;
      r.want.volume_changed = vchg;
      r.want.pan_changed    = pchg;
      directed.push_back(r);
   endtask

   // Directed items; the expected result is written in only where it is obvious.
   task automatic build_directed();
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 15, 0, 0);
      add_row(vpfa_pkg::CMD_SET_VOL,  8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 255, 15, 1, 0);
      add_row(vpfa_pkg::CMD_REL_VOL,  8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 15, 1, 0);
      add_row(vpfa_pkg::CMD_REL_VOL,  8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 255, 15, 1, 0);
      add_row(vpfa_pkg::CMD_SET_VOL,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 15, 1, 0);
      add_row(vpfa_pkg::CMD_SET_PAN,  8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 30, 0, 1);
      add_row(vpfa_pkg::CMD_SET_PAN,  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 0, 0, 1);
      add_row(vpfa_pkg::CMD_SET_PAN,  8'd31, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 30, 0, 1);
      add_row(vpfa_pkg::CMD_SET_PAN,  8'd15, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 15, 0, 1);
      add_row(CMD_SPARE_6, 8'd255, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 1, 0, 15, 0, 0);
      add_row(CMD_SPARE_7, 8'd255, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 1, 0, 15, 0, 0);
      // A volume fade with a zero step is loaded but never runs.
      add_row(vpfa_pkg::CMD_VOL_FADE, 8'd0, 8'h00, 8'd0, 8'd1, 8'd1, 8'd0, 1, 0, 15, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 15, 0, 0);
      // Two downward steps that wrap below zero, then nothing.
      add_row(vpfa_pkg::CMD_VOL_FADE, 8'd0, 8'hFF, 8'd0, 8'd1, 8'd2, 8'd0, 1, 0, 15, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      // A long fade with the largest step count, cancelled by a volume write.
      add_row(vpfa_pkg::CMD_VOL_FADE, 8'd0, 8'h7F, 8'd255, 8'd255, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_SET_VOL,  8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 128, 15, 1, 0);
      // A pan fade whose goal is already the current pan stays inactive.
      add_row(vpfa_pkg::CMD_PAN_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_PAN_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_SET_PAN,  8'd14, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1, 128, 14, 0, 1);
      // Oscillation around center: the mirrored goal is again 15.
      add_row(vpfa_pkg::CMD_PAN_FADE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd30, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
      add_row(vpfa_pkg::CMD_TICK,     8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 0, 0);
   endtask

   // Random item: mostly ticks and short fades so that automation really runs.
   function automatic vpfa_pkg::vpfa_req_type random_item();
      vpfa_pkg::vpfa_req_type it;
      int unsigned            pick;
      bit                     tame;
      it.command     = vpfa_pkg::CMD_TICK;
      it.level_value = 8'($urandom_range(255, 0));
      it.fade_step   = 8'($urandom_range(255, 0));
      it.delay       = 8'($urandom_range(255, 0));
      it.interval    = 8'($urandom_range(255, 0));
      it.count       = 8'($urandom_range(255, 0));
      it.endpoint    = 8'($urandom_range(255, 0));
      pick = $urandom_range(99, 0);
      tame = ($urandom_range(4, 0) != 0);
      if (pick < 50) begin
         it.command = vpfa_pkg::CMD_TICK;
      end else if (pick < 57) begin
         it.command = vpfa_pkg::CMD_SET_VOL;
      end else if (pick < 64) begin
         it.command = vpfa_pkg::CMD_REL_VOL;
      end else if (pick < 71) begin
         it.command = vpfa_pkg::CMD_SET_PAN;
         if (tame) begin
            it.level_value = 8'($urandom_range(30, 0));
         end
      end else if (pick < 83) begin
         it.command = vpfa_pkg::CMD_PAN_FADE;
         if (tame) begin
            it.delay    = 8'($urandom_range(3, 0));
            it.interval = 8'($urandom_range(2, 0));
            it.endpoint = 8'($urandom_range(61, 0));
         end
      end else if (pick < 95) begin
         it.command = vpfa_pkg::CMD_VOL_FADE;
         if (tame) begin
            it.delay    = 8'($urandom_range(3, 0));
            it.interval = 8'($urandom_range(3, 1));
            it.count    = 8'($urandom_range(8, 1));
         end
         if ($urandom_range(9, 0) == 0) begin
            it.fade_step = 8'sd0;
         end
      end else if (pick < 97) begin
         it.command = ($urandom_range(1, 0) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else begin
         // Oscillating pan fade around center, which lets the pan wrap.
         it.command  = vpfa_pkg::CMD_PAN_FADE;
         it.endpoint = 8'd30;
         it.delay    = 8'($urandom_range(2, 0));
         it.interval = 8'($urandom_range(1, 0));
      end
      return it;
   endfunction

   // Offers one item until the block takes it, then records what it should return.
   task automatic offer_item(input vpfa_pkg::vpfa_req_type it, input bit typed,
                             input vpfa_pkg::vpfa_rsp_type typed_want);
      vpfa_pkg::vpfa_rsp_type predicted;
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_levels(it, predicted);
      levels_due.push_back(typed ? typed_want : predicted);
   endtask

   // Bursts of items with idle gaps between them; no gaps during a hold-off.
   task automatic pace();
      int unsigned gap;
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0 && !hold_active) begin
         if ($urandom_range(3, 0) == 0) begin
            burst_left = $urandom_range(80, 30);
         end else begin
            burst_left = $urandom_range(24, 1);
            gap        = $urandom_range(6, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input vpfa_pkg::vpfa_rsp_type want,
                                input vpfa_pkg::vpfa_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected vol %0d pan %0d vchg %0b pchg %0b", what,
                  want.volume_level, want.pan_position, want.volume_changed,
                  want.pan_changed);
         $display("   got vol %0d pan %0d vchg %0b pchg %0b", got.volume_level,
                  got.pan_position, got.volume_changed, got.pan_changed);
      end
   endtask

   // Stimulus: reset, the directed table, the random items, then the drain.
   initial begin : drive_items
      int unsigned            k;
      vpfa_pkg::vpfa_rsp_type none;
      none = '0;
      build_directed();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         offer_item(directed[i].item, directed[i].typed, directed[i].want);
         pace();
      end
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         offer_item(random_item(), 1'b0, none);
         pace();
      end
      req_valid <= 1'b0;
      while (levels_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && levels_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Result side: check each accepted item, then choose the next stall value.
   always @(posedge clock) begin : take_results
      vpfa_pkg::vpfa_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (levels_due.size() == 0) begin
            flag_mismatch("unexpected result", '0, rsp_item);
         end else begin
            want = levels_due.pop_front();
            if (rsp_item.volume_level !== want.volume_level
                || rsp_item.pan_position !== want.pan_position
                || rsp_item.volume_changed !== want.volume_changed
                || rsp_item.pan_changed !== want.pan_changed) begin
               flag_mismatch("wrong result", want, rsp_item);
            end
         end
         results_seen++;
         // Long hold-offs so that both block registers fill and the input stalls.
         if (results_seen == 40 || results_seen == 1000) begin
            hold_left = HOLD_CYCLES;
         end
      end
      stall_clock++;
      if (stall_clock % 100 == 0) begin
         stall_mode = stall_kind_type'($urandom_range(3, 0));
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_LIGHT:       rsp_stall <= ($urandom_range(3, 0) == 0);
            STALL_HEAVY:       rsp_stall <= ($urandom_range(3, 0) != 0);
            STALL_EVERY_THIRD: rsp_stall <= (stall_clock % 3 == 0);
            default:           rsp_stall <= 1'b0;
         endcase
      end
      hold_active <= (hold_left != 0);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
